@@ rtl/srsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsm_pkg: shared types and constants of the sorted range set merge core
// Holds the input and result transfer formats and the fixed field widths.
// ----------------------------------------------------------------------------
package srsm_pkg;

  localparam int unsigned ID_W       = 16;
  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned DUMP_LIMIT = 16;
  localparam int unsigned ENTRY_W    = 2 * ID_W;

  typedef struct packed {
    logic [ID_W-1:0] range_start;
    logic [ID_W-1:0] range_end;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] entry_index;
    logic [ID_W-1:0]    entry_first;
    logic [ID_W-1:0]    entry_last_id;
    logic [COUNT_W-1:0] entry_count;
    logic               rejected;
    logic               last;
  } out_item_t;

endpackage

@@ rtl/srsm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsm_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value in cycles without a read.
// ----------------------------------------------------------------------------
module srsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

@@ rtl/sorted_range_set_merge_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_range_set_merge_core: sorted ID range table with union merge
// Inserts one range per input transfer, merges touching neighbors and
// dumps the resulting table, one result transfer per entry.
// ----------------------------------------------------------------------------
// Order: an input transfer is followed by the PREP read, the MERGE walk,
//   the FLUSH write, the DSTART read and the DUMP; results follow one per
//   cycle while out_ready allows. The next insert waits for the dump, as
//   the single table RAM read port serves both the merge walk and the dump.
// Reset: the entry count clears to zero; the table RAM is not cleared.
// ----------------------------------------------------------------------------
module sorted_range_set_merge_core #(
  parameter int unsigned MAX_RANGES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  srsm_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output srsm_pkg::out_item_t   out_data
);

  import srsm_pkg::*;

  localparam int unsigned IW    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW    = $clog2(MAX_RANGES + 1);
  localparam int unsigned AW    = IW + 1;
  localparam int unsigned DEPTH = 2 ** AW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MERGE,
    ST_FLUSH,
    ST_DSTART,
    ST_DUMP
  } state_t;

  state_t              state_r, state_nxt;
  logic [ID_W-1:0]     ns_r, ns_nxt, ne_r, ne_nxt;
  logic [ID_W-1:0]     cs_r, cs_nxt, ce_r, ce_nxt;
  logic                ins_r, ins_nxt, have_r, have_nxt, rej_r, rej_nxt;
  logic                bank_r, bank_nxt;
  logic [CW-1:0]       count_r, count_nxt, i_r, i_nxt, m_r, m_nxt;
  logic [COUNT_W-1:0]  k_r, k_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                ram_wr_en, ram_rd_en;
  logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
  logic [ENTRY_W-1:0]  ram_wr_data, ram_rd_data;
  logic [ID_W-1:0]     rd_s, rd_e, el_s, el_e;

  logic [CW-1:0]       i_inc;
  logic [COUNT_W-1:0]  k_inc, dump_n;
  logic [31:0]         cnt_ext, k_ext, k_inc_ext;
  logic                take_new, walk_done, merge_hit, wr_room, out_free;

  srsm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_s      = ram_rd_data[ENTRY_W-1:ID_W];
  assign rd_e      = ram_rd_data[ID_W-1:0];
  assign i_inc     = i_r + 1'b1;
  assign k_inc     = k_r + 1'b1;
  assign cnt_ext   = 32'(count_r);
  assign k_ext     = 32'(k_r);
  assign k_inc_ext = 32'(k_inc);
  assign dump_n    = (cnt_ext > 32'(DUMP_LIMIT)) ? COUNT_W'(DUMP_LIMIT) : cnt_ext[COUNT_W-1:0];

  // The new range enters the stream ahead of the first stored start that is
  // strictly greater, or after the last stored entry.
  assign walk_done = (i_r == count_r);
  assign take_new  = !ins_r && (walk_done || (ns_r < rd_s));
  assign el_s      = take_new ? ns_r : rd_s;
  assign el_e      = take_new ? ne_r : rd_e;
  assign merge_hit = ({1'b0, ce_r} + 17'd1) >= {1'b0, el_s};
  assign wr_room   = (m_r != CW'(MAX_RANGES));
  assign out_free  = !out_valid_r || out_ready;

  assign ram_wr_addr = {~bank_r, m_r[IW-1:0]};
  assign ram_wr_data = {cs_r, ce_r};

  always_comb begin
    state_nxt     = state_r;
    ns_nxt        = ns_r;
    ne_nxt        = ne_r;
    cs_nxt        = cs_r;
    ce_nxt        = ce_r;
    ins_nxt       = ins_r;
    have_nxt      = have_r;
    rej_nxt       = rej_r;
    bank_nxt      = bank_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = {bank_r, {IW{1'b0}}};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ns_nxt    = in_data.range_start;
          ne_nxt    = in_data.range_end;
          ins_nxt   = 1'b0;
          have_nxt  = 1'b0;
          rej_nxt   = 1'b0;
          i_nxt     = '0;
          m_nxt     = '0;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        ram_rd_en = 1'b1;
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        if (walk_done && ins_r) begin
          state_nxt = ST_FLUSH;
        end else begin
          if (take_new) begin
            ins_nxt = 1'b1;
          end else begin
            // Fetch the following stored entry while this one is consumed.
            i_nxt       = i_inc;
            ram_rd_en   = 1'b1;
            ram_rd_addr = {bank_r, i_inc[IW-1:0]};
          end
          if (!have_r) begin
            have_nxt = 1'b1;
            cs_nxt   = el_s;
            ce_nxt   = el_e;
          end else if (merge_hit) begin
            if (el_e > ce_r) begin
              ce_nxt = el_e;
            end
          end else begin
            if (wr_room) begin
              ram_wr_en = 1'b1;
              m_nxt     = m_r + 1'b1;
            end else begin
              rej_nxt = 1'b1;
            end
            cs_nxt = el_s;
            ce_nxt = el_e;
          end
        end
      end
      ST_FLUSH: begin
        if (wr_room && !rej_r) begin
          ram_wr_en = 1'b1;
          count_nxt = m_r + 1'b1;
          bank_nxt  = ~bank_r;
        end else begin
          rej_nxt = 1'b1;
        end
        k_nxt     = '0;
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        ram_rd_en = 1'b1;
        state_nxt = ST_DUMP;
      end
      ST_DUMP: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.entry_index   = k_r[INDEX_W-1:0];
          out_data_nxt.entry_first   = rd_s;
          out_data_nxt.entry_last_id = rd_e;
          out_data_nxt.entry_count   = cnt_ext[COUNT_W-1:0];
          out_data_nxt.rejected      = rej_r;
          out_data_nxt.last          = (k_inc == dump_n);
          if (k_inc == dump_n) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt       = k_inc;
            ram_rd_en   = 1'b1;
            ram_rd_addr = {bank_r, k_inc_ext[IW-1:0]};
          end
        end else begin
          ram_rd_addr = {bank_r, k_ext[IW-1:0]};
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ns_r       <= ns_nxt;
    ne_r       <= ne_nxt;
    cs_r       <= cs_nxt;
    ce_r       <= ce_nxt;
    i_r        <= i_nxt;
    m_r        <= m_nxt;
    k_r        <= k_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ins_r       <= 1'b0;
      have_r      <= 1'b0;
      rej_r       <= 1'b0;
      bank_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ins_r       <= ins_nxt;
      have_r      <= have_nxt;
      rej_r       <= rej_nxt;
      bank_r      <= bank_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again while an insert is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CW'(MAX_RANGES)))
    else $error("entry count exceeds table capacity");

  a_bank_swap_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (bank_r != $past(bank_r)) |-> (!rej_r && (state_r == ST_DSTART)))
    else $error("table bank switched outside a successful insert");

  a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (m_r <= CW'(MAX_RANGES)) && (i_r <= count_r))
    else $error("merge walk counters out of range");
`endif

endmodule
